[src/u8u16_pkg.sv]
// ============================================================================
// UTF-8 to UTF-16 transcoder package
// Shared result types and code point constants of the transcoder.
// ============================================================================
package u8u16_pkg;

    localparam int CODE_W = 21;
    localparam int UNIT_W = 16;

    localparam logic [UNIT_W-1:0] REPLACEMENT_CHAR = 16'hFFFD;
    localparam logic [CODE_W-1:0] SUPP_BASE        = 21'h10000;
    localparam logic [UNIT_W-1:0] SURR_HI_BASE     = 16'hD800;
    localparam logic [5:0]        SURR_LO_PREFIX   = 6'b110111;

    typedef struct packed {
        logic [UNIT_W-1:0] code_unit;
        logic              unit_valid;
        logic              string_end;
        logic              run_last;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_dec_out;

endpackage

[src/u8u16_if.sv]
// ============================================================================
// Transcoder stream interfaces
// Valid/ready channels for UTF-8 bytes in and UTF-16 code units out.
// ============================================================================
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       final_byte;

    modport source (output valid, output in_byte, output final_byte, input ready);
    modport sink (input valid, input in_byte, input final_byte, output ready);
endinterface

interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        unit_valid;
    logic        string_end;
    logic        run_last;

    modport source (output valid, output code_unit, output unit_valid,
                    output string_end, output run_last, input ready);
    modport sink (input valid, input code_unit, input unit_valid,
                  input string_end, input run_last, output ready);
endinterface

[src/u8u16_decoder.sv]
// ============================================================================
// UTF-8 sequence decoder
// Holds the sequence state and turns one byte into zero, one or two results.
// ============================================================================
module u8u16_decoder
    import u8u16_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_byte,
    input  logic       i_final,
    output t_dec_out   o_dec
);

    logic [1:0]        r_bytes_left;
    logic [CODE_W-1:0] r_code_accum;
    logic              r_bad_sequence;

    logic [1:0]        n_bytes_left;
    logic [CODE_W-1:0] n_code_accum;
    logic              n_bad_sequence;

    logic              done;
    logic [CODE_W-1:0] code;
    logic [CODE_W-1:0] supp;
    t_result           unit_a;
    t_result           unit_b;
    logic [1:0]        count;

    always_comb begin
        n_bytes_left   = r_bytes_left;
        n_code_accum   = r_code_accum;
        n_bad_sequence = r_bad_sequence;
        done           = 1'b0;
        code           = '0;
        if (r_bytes_left == 2'd0) begin
            if (!i_byte[7]) begin
                code = {13'd0, i_byte};
                done = 1'b1;
            end else if (i_byte[7:5] == 3'b110) begin
                n_code_accum   = {16'd0, i_byte[4:0]};
                n_bytes_left   = 2'd1;
                n_bad_sequence = 1'b0;
            end else if (i_byte[7:4] == 4'b1110) begin
                n_code_accum   = {17'd0, i_byte[3:0]};
                n_bytes_left   = 2'd2;
                n_bad_sequence = 1'b0;
            end else if (i_byte[7:3] == 5'b11110) begin
                n_code_accum   = {18'd0, i_byte[2:0]};
                n_bytes_left   = 2'd3;
                n_bad_sequence = 1'b0;
            end
        end else begin
            if (!r_bad_sequence) begin
                if (i_byte[7:6] != 2'b10) begin
                    n_bad_sequence = 1'b1;
                end else begin
                    n_code_accum = {r_code_accum[CODE_W-7:0], i_byte[5:0]};
                end
            end
            n_bytes_left = r_bytes_left - 2'd1;
            if (n_bytes_left == 2'd0) begin
                code = n_bad_sequence ? {5'd0, REPLACEMENT_CHAR} : n_code_accum;
                done = 1'b1;
            end
        end
    end

    assign supp = code - SUPP_BASE;

    always_comb begin
        unit_a = '0;
        unit_b = '0;
        count  = 2'd0;
        if (done) begin
            unit_a.unit_valid = 1'b1;
            if (code[CODE_W-1:UNIT_W] == '0) begin
                unit_a.code_unit = code[UNIT_W-1:0];
                count            = 2'd1;
            end else begin
                unit_a.code_unit  = SURR_HI_BASE + {5'd0, supp[CODE_W-1:10]};
                unit_b.code_unit  = {SURR_LO_PREFIX, supp[9:0]};
                unit_b.unit_valid = 1'b1;
                count             = 2'd2;
            end
        end
        if (i_final && count == 2'd0) begin
            count = 2'd1;
        end
        if (count == 2'd2) begin
            unit_b.string_end = i_final;
            unit_b.run_last   = 1'b1;
        end else begin
            unit_a.string_end = i_final;
            unit_a.run_last   = 1'b1;
        end
    end

    assign o_dec.count  = count;
    assign o_dec.first  = unit_a;
    assign o_dec.second = unit_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_left   <= 2'd0;
            r_code_accum   <= '0;
            r_bad_sequence <= 1'b0;
        end else if (i_accept) begin
            if (i_final) begin
                r_bytes_left   <= 2'd0;
                r_code_accum   <= '0;
                r_bad_sequence <= 1'b0;
            end else begin
                r_bytes_left   <= n_bytes_left;
                r_code_accum   <= n_code_accum;
                r_bad_sequence <= n_bad_sequence;
            end
        end
    end

endmodule

[src/utf8_to_utf16_transcoder_unit.sv]
// ============================================================================
// UTF-8 to UTF-16 transcoder
// Converts UTF-8 bytes to UTF-16 code units, one byte a cycle unless stalled.
// ============================================================================
// Usage:
// The input channel carries one UTF-8 byte per transfer, with final_byte set
// on the last byte of a string. The output channel carries one UTF-16 code
// unit per transfer, with string_end on the last result of a string and
// run_last on the last result caused by an input byte. A string whose last
// byte produces no unit closes with a bare end marker (unit_valid low).
// Each accepted byte is decoded in the cycle of its transfer and its results
// are written into a four-entry result queue, whose head drives the output.
// Input is taken whenever the queue holds at most two results, so one byte
// per cycle is sustained while the receiver keeps up; a surrogate pair
// occupies two output transfers and the queue absorbs it. When the receiver
// stalls, results stay in the queue and input stops once three are waiting.
// Reset clears the sequence state and empties the queue; no output is valid
// in the cycle after reset.
// ============================================================================
module utf8_to_utf16_transcoder_unit
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16_in_if.sink    i_in,
    u8u16_out_if.source o_out
);

    localparam int QUEUE_DEPTH = 4;

    t_result    r_queue [QUEUE_DEPTH];
    logic [2:0] r_count;
    t_result    n_queue [QUEUE_DEPTH];
    logic [2:0] n_count;

    logic       accept;
    logic       pop;
    logic [2:0] base;
    t_dec_out   dec;

    assign i_in.ready = (r_count < 3'(QUEUE_DEPTH - 1));
    assign accept     = i_in.valid && i_in.ready;
    assign pop        = (r_count != 3'd0) && o_out.ready;

    u8u16_decoder u_decoder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_accept(accept),
        .i_byte  (i_in.in_byte),
        .i_final (i_in.final_byte),
        .o_dec   (dec)
    );

    always_comb begin
        base = r_count - {2'b00, pop};
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && i < QUEUE_DEPTH - 1) begin
                n_queue[i] = r_queue[(i + 1) % QUEUE_DEPTH];
            end else begin
                n_queue[i] = r_queue[i];
            end
            if (accept && dec.count != 2'd0 && base == 3'(i)) begin
                n_queue[i] = dec.first;
            end
            if (accept && dec.count == 2'd2 && base + 3'd1 == 3'(i)) begin
                n_queue[i] = dec.second;
            end
        end
        n_count = accept ? base + {1'b0, dec.count} : base;
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_queue[i] <= n_queue[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 3'd0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_out.valid      = (r_count != 3'd0);
    assign o_out.code_unit  = r_queue[0].code_unit;
    assign o_out.unit_valid = r_queue[0].unit_valid;
    assign o_out.string_end = r_queue[0].string_end;
    assign o_out.run_last   = r_queue[0].run_last;

endmodule

[src/u8u16_checker.sv]
// ============================================================================
// Transcoder port checker
// Watches the transcoder's ports for result framing and stall behavior.
// ============================================================================
module u8u16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_code_unit,
    input logic        i_unit_valid,
    input logic        i_string_end,
    input logic        i_run_last
);

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("Output valid in the cycle after reset.");

    a_marker_framing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_unit_valid |-> i_string_end && i_run_last)
        else $error("Bare end marker without string end and run last.");

    a_marker_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_unit_valid |-> i_code_unit == 16'd0)
        else $error("Bare end marker carries a nonzero code unit.");

    a_end_closes_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_string_end |-> i_run_last)
        else $error("String end without run last.");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_code_unit)
            && $stable(i_unit_valid) && $stable(i_string_end) && $stable(i_run_last))
        else $error("Stalled output transfer changed.");

endmodule

bind utf8_to_utf16_transcoder_unit u8u16_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_code_unit (o_out.code_unit),
    .i_unit_valid(o_out.unit_valid),
    .i_string_end(o_out.string_end),
    .i_run_last  (o_out.run_last)
);

[tb/u8u16_check_pkg.sv]
// ============================================================================
// Transcoder checking package
// Holds the scoreboard that decodes each accepted UTF-8 byte on its own and
// compares the UTF-16 code units of the block with the units it predicts.
// ============================================================================
package u8u16_check_pkg;

    import u8u16_pkg::*;

    localparam logic [CODE_W-1:0] BMP_LAST = 21'h0FFFF;

    class transcode_board;
        logic [1:0]        bytes_left;
        logic [CODE_W-1:0] code_accum;
        logic              bad_sequence;
        t_result           expected_units[$];
        int                errors;
        int                units_checked;
        int                bytes_taken;
        int                strings_closed;
        int                pairs_seen;
        int                replacements;
        int                bare_markers;
        int                skipped_leads;

        function new();
            clear_sequence();
            errors         = 0;
            units_checked  = 0;
            bytes_taken    = 0;
            strings_closed = 0;
            pairs_seen     = 0;
            replacements   = 0;
            bare_markers   = 0;
            skipped_leads  = 0;
        endfunction

        function void clear_sequence();
            bytes_left   = 2'd0;
            code_accum   = '0;
            bad_sequence = 1'b0;
        endfunction

        function void take_byte(logic [7:0] b, logic fin);
            t_result           step_units[2];
            logic [CODE_W-1:0] cp;
            logic [CODE_W-1:0] offset;
            logic              done;
            int                n;
            done = 1'b0;
            cp   = '0;
            n    = 0;
            bytes_taken++;
            if (bytes_left == 2'd0) begin
                if (b[7] == 1'b0) begin
                    cp   = CODE_W'(b);
                    done = 1'b1;
                end else if (b[7:5] == 3'b110) begin
                    code_accum   = CODE_W'(b[4:0]);
                    bytes_left   = 2'd1;
                    bad_sequence = 1'b0;
                end else if (b[7:4] == 4'b1110) begin
                    code_accum   = CODE_W'(b[3:0]);
                    bytes_left   = 2'd2;
                    bad_sequence = 1'b0;
                end else if (b[7:3] == 5'b11110) begin
                    code_accum   = CODE_W'(b[2:0]);
                    bytes_left   = 2'd3;
                    bad_sequence = 1'b0;
                end else begin
                    skipped_leads++;
                end
            end else begin
                if (!bad_sequence) begin
                    if (b[7:6] != 2'b10) begin
                        bad_sequence = 1'b1;
                    end else begin
                        code_accum = {code_accum[CODE_W-7:0], b[5:0]};
                    end
                end
                bytes_left = bytes_left - 2'd1;
                if (bytes_left == 2'd0) begin
                    cp   = bad_sequence ? CODE_W'(REPLACEMENT_CHAR) : code_accum;
                    done = 1'b1;
                    if (bad_sequence) begin
                        replacements++;
                    end
                end
            end

            if (done) begin
                if (cp <= BMP_LAST) begin
                    step_units[0] = t_result'{cp[UNIT_W-1:0], 1'b1, 1'b0, 1'b0};
                    n = 1;
                end else begin
                    offset        = cp - SUPP_BASE;
                    step_units[0] = t_result'{SURR_HI_BASE + UNIT_W'(offset >> 10),
                                              1'b1, 1'b0, 1'b0};
                    step_units[1] = t_result'{{SURR_LO_PREFIX, offset[9:0]},
                                              1'b1, 1'b0, 1'b0};
                    n = 2;
                    pairs_seen++;
                end
            end

            if (fin) begin
                if (n == 0) begin
                    step_units[0] = t_result'{'0, 1'b0, 1'b0, 1'b0};
                    n = 1;
                    bare_markers++;
                end
                step_units[n-1].string_end = 1'b1;
                strings_closed++;
                clear_sequence();
            end

            if (n > 0) begin
                step_units[n-1].run_last = 1'b1;
            end
            for (int k = 0; k < n; k++) begin
                expected_units.insert(expected_units.size(), step_units[k]);
            end
        endfunction

        function void check_unit(t_result got);
            t_result want;
            if (expected_units.size() == 0) begin
                $error("code unit %h arrived with no unit pending", got.code_unit);
                errors++;
                return;
            end
            want = expected_units.pop_front();
            units_checked++;
            if (got.code_unit !== want.code_unit) begin
                $error("code_unit: expected %h, actual %h", want.code_unit, got.code_unit);
                errors++;
            end
            if (got.unit_valid !== want.unit_valid) begin
                $error("unit_valid: expected %b, actual %b", want.unit_valid, got.unit_valid);
                errors++;
            end
            if (got.string_end !== want.string_end) begin
                $error("string_end: expected %b, actual %b", want.string_end, got.string_end);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $error("run_last: expected %b, actual %b", want.run_last, got.run_last);
                errors++;
            end
        endfunction
    endclass

endpackage

[tb/tb_top.sv]
// ============================================================================
// UTF-8 to UTF-16 transcoder testbench
// Sends directed and random UTF-8 strings (well-formed sequences, stray and
// malformed bytes, cut-off sequences) with random gaps and stalls on both
// channels, and checks every code unit against the scoreboard's prediction.
// ============================================================================
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;
    import u8u16_check_pkg::*;

    localparam int TARGET_BYTES = 1040;
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 20;

    logic i_clk = 1'b0;
    logic i_rst_n;

    u8u16_in_if  in_bus();
    u8u16_out_if out_bus();

    utf8_to_utf16_transcoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    transcode_board board;
    logic [7:0]     string_bytes[$];
    bit             hold_request;
    bit             rx_burst;
    bit             tx_burst;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end else begin
            return $urandom_range(20, 60);
        end
    endfunction

    function automatic void queue_byte(logic [7:0] b);
        string_bytes.insert(string_bytes.size(), b);
    endfunction

    function automatic void append_sequence(int len, int followers, bit spoil);
        logic [7:0] b;
        int         bad_pos;
        case (len)
            1: begin
                queue_byte({1'b0, 7'($urandom)});
            end
            2: begin
                queue_byte({3'b110, 5'($urandom)});
            end
            3: begin
                queue_byte({4'b1110, 4'($urandom)});
            end
            default: begin
                queue_byte({5'b11110, 3'($urandom)});
            end
        endcase
        bad_pos = (spoil && followers > 0) ? $urandom_range(1, followers) : 0;
        for (int k = 1; k <= followers; k++) begin
            if (k == bad_pos) begin
                do b = 8'($urandom); while (b[7:6] == 2'b10);
            end else begin
                b = {2'b10, 6'($urandom)};
            end
            queue_byte(b);
        end
    endfunction

    function automatic void build_random_string();
        int count;
        int pick;
        int len;
        string_bytes.delete();
        count = $urandom_range(1, 6);
        for (int s = 0; s < count; s++) begin
            pick = $urandom_range(0, 99);
            len  = $urandom_range(1, 4);
            if (pick < 84) begin
                append_sequence(len, len - 1, 1'b0);
            end else if (pick < 90) begin
                queue_byte($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                : 8'($urandom_range(8'hF8, 8'hFF)));
            end else if (pick < 96) begin
                len = $urandom_range(2, 4);
                append_sequence(len, len - 1, 1'b1);
            end else begin
                queue_byte(8'($urandom));
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            len = $urandom_range(2, 4);
            append_sequence(len, $urandom_range(0, len - 2), 1'b0);
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin);
        int gap;
        gap = tx_burst ? 0 : pick_gap();
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid      <= 1'b1;
        in_bus.in_byte    <= b;
        in_bus.final_byte <= fin;
        do @(posedge i_clk); while (in_bus.ready !== 1'b1);
        board.take_byte(b, fin);
        @(negedge i_clk);
    endtask

    task automatic send_string();
        for (int i = 0; i < string_bytes.size(); i++) begin
            send_byte(string_bytes[i], i == string_bytes.size() - 1);
        end
    endtask

    task automatic wait_drained();
        in_bus.valid <= 1'b0;
        @(negedge i_clk);
        while (board.expected_units.size() != 0) @(negedge i_clk);
    endtask

    // Receiver side: random stalls, bursts of full rate, and one long hold-off.
    initial begin
        int stall_left;
        int hold_left;
        out_bus.ready = 1'b0;
        stall_left    = 0;
        hold_left     = 0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_left    = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 199) == 0) begin
                rx_burst = !rx_burst;
            end
            if (hold_left > 0) begin
                out_bus.ready <= 1'b0;
                hold_left--;
            end else if (stall_left > 0) begin
                out_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                out_bus.ready <= 1'b1;
                stall_left = rx_burst ? 0 : pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
            board.check_unit(t_result'{out_bus.code_unit, out_bus.unit_valid,
                                       out_bus.string_end, out_bus.run_last});
        end
    end

    initial begin
        #8_000_000;
        $display("Timed out with %0d units still pending.", board.expected_units.size());
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        bit held;
        bit paused;
        int burst_strings;
        board             = new();
        i_rst_n           = 1'b0;
        in_bus.valid      = 1'b0;
        in_bus.in_byte    = '0;
        in_bus.final_byte = 1'b0;
        hold_request      = 1'b0;
        rx_burst          = 1'b0;
        tx_burst          = 1'b0;
        held              = 1'b0;
        paused            = 1'b0;
        burst_strings     = 0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // ASCII extremes, two and three byte forms, and surrogate pairs.
        string_bytes = {8'h00};
        send_string();
        string_bytes = {8'h7F, 8'hC3, 8'hA9};
        send_string();
        string_bytes = {8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_string();
        // A four byte code beyond the legal range is still split into a pair.
        string_bytes = {8'hF7, 8'hBF, 8'hBF, 8'hBF};
        send_string();
        // A stray continuation byte as the whole string leaves a bare end marker.
        string_bytes = {8'h80};
        send_string();
        string_bytes = {8'hF8, 8'hFF, 8'hE2, 8'h41, 8'h42};
        send_string();
        // A sequence cut off by the final byte is dropped.
        string_bytes = {8'hC3};
        send_string();
        wait_drained();

        while (board.bytes_taken < TARGET_BYTES) begin
            tx_burst = ($urandom_range(0, 3) == 0);
            if (!held && board.bytes_taken >= 400) begin
                hold_request  = 1'b1;
                held          = 1'b1;
                burst_strings = 12;
            end
            if (burst_strings > 0) begin
                tx_burst = 1'b1;
                burst_strings--;
            end
            if (!paused && board.bytes_taken >= 700) begin
                wait_drained();
                paused = 1'b1;
            end
            build_random_string();
            send_string();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);

        $display("Sent %0d bytes in %0d strings and checked %0d code units.",
                 board.bytes_taken, board.strings_closed, board.units_checked);
        $display("Seen: %0d surrogate pairs, %0d replacements, %0d bare ends, %0d skipped leads.",
                 board.pairs_seen, board.replacements, board.bare_markers, board.skipped_leads);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
